>>> src/wsaa_pkg.sv
// shared types and constants for the windowed sensor average alert block
package wsaa_pkg;

  // field widths of the sensor channels
  localparam int CO2_W = 16;
  localparam int HUM_W = 14;
  localparam int TMP_W = 15;

  // configuration port
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_ADDR_W-1:0] REG_CO2_LIMIT = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_TMP_LIMIT = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_HUM_LIMIT = 2'd2;

  localparam logic [CO2_W-1:0]        CO2_LIMIT_RST = 16'd1000;
  localparam logic signed [TMP_W-1:0] TMP_LIMIT_RST = 15'sd3000;
  localparam logic [HUM_W-1:0]        HUM_LIMIT_RST = 14'd7000;

  // co2 grade levels
  localparam int GRADE_W = 2;
  localparam logic [GRADE_W-1:0] GRADE_NONE = 2'd0;
  localparam logic [GRADE_W-1:0] GRADE_LOW  = 2'd1;
  localparam logic [GRADE_W-1:0] GRADE_MID  = 2'd2;
  localparam logic [GRADE_W-1:0] GRADE_HIGH = 2'd3;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic update;
    logic mul_load;
    logic load_out;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic div_done;
  } dp_status_t;

endpackage

>>> src/wsaa_if.sv
// request and result channel interfaces of the windowed sensor average alert block
interface wsaa_in_if;
  logic                                   valid;
  logic                                   ready;
  logic [wsaa_pkg::CO2_W-1:0]             co2_sample;
  logic [wsaa_pkg::HUM_W-1:0]             humidity_sample;
  logic signed [wsaa_pkg::TMP_W-1:0]      temperature_sample;
  logic                                   sample_valid;
  logic                                   restart;

  modport source (
    output valid, co2_sample, humidity_sample, temperature_sample, sample_valid, restart,
    input  ready
  );
  modport sink (
    input  valid, co2_sample, humidity_sample, temperature_sample, sample_valid, restart,
    output ready
  );
endinterface

interface wsaa_out_if #(
  parameter int WINDOW_SIZE = 64
);
  localparam int CNT_W = $clog2(WINDOW_SIZE + 1);

  logic                                   valid;
  logic                                   ready;
  logic [wsaa_pkg::CO2_W-1:0]             avg_co2;
  logic [wsaa_pkg::HUM_W-1:0]             avg_humidity;
  logic signed [wsaa_pkg::TMP_W-1:0]      avg_temperature;
  logic                                   average_valid;
  logic                                   window_full;
  logic [CNT_W-1:0]                       sample_count;
  logic                                   co2_alert;
  logic                                   temperature_alert;
  logic                                   humidity_alert;
  logic                                   any_alert;
  logic [wsaa_pkg::GRADE_W-1:0]           co2_grade;

  modport source (
    output valid, avg_co2, avg_humidity, avg_temperature, average_valid, window_full,
           sample_count, co2_alert, temperature_alert, humidity_alert, any_alert, co2_grade,
    input  ready
  );
  modport sink (
    input  valid, avg_co2, avg_humidity, avg_temperature, average_valid, window_full,
           sample_count, co2_alert, temperature_alert, humidity_alert, any_alert, co2_grade,
    output ready
  );
endinterface

>>> src/wsaa_div.sv
// radix-2 restoring divider, several lanes sharing one divisor and step counter
module wsaa_div #(
  parameter int DIV_W = 22,
  parameter int CNT_W = 7,
  parameter int LANES = 3
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [CNT_W-1:0] divisor,
  input  logic [DIV_W-1:0] dividend [LANES],
  output logic [DIV_W-1:0] quot     [LANES],
  output logic             done
);

  localparam int STEP_W = $clog2(DIV_W + 1);

  logic [STEP_W-1:0] step_r;
  logic [CNT_W-1:0]  dvs_r;
  logic [CNT_W-1:0]  rem_r [LANES];
  logic [DIV_W-1:0]  q_r   [LANES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
    end else if (start) begin
      step_r <= STEP_W'(DIV_W);
    end else if (step_r != '0) begin
      step_r <= step_r - STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvs_r <= divisor;
    end
  end

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    logic [CNT_W:0]   rem_sh;
    logic [CNT_W:0]   rem_sub;
    logic             fits;

    always_comb begin
      rem_sh  = {rem_r[i], q_r[i][DIV_W-1]};
      rem_sub = rem_sh - {1'b0, dvs_r};
      fits    = (rem_sh >= {1'b0, dvs_r});
    end

    always_ff @(posedge clk) begin
      if (start) begin
        rem_r[i] <= '0;
        q_r[i]   <= dividend[i];
      end else if (step_r != '0) begin
        rem_r[i] <= fits ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
        q_r[i]   <= {q_r[i][DIV_W-2:0], fits};
      end
    end

    assign quot[i] = q_r[i];
  end

  assign done = (step_r == '0);

endmodule

>>> src/wsaa_ctrl.sv
// sequencing state machine of the windowed sensor average alert block
module wsaa_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  logic                   out_ready,
  input  wsaa_pkg::dp_status_t   status,
  output wsaa_pkg::ctrl_cmd_t    cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_UPD  = 2'd1;
  localparam logic [1:0] ST_MUL  = 2'd2;
  localparam logic [1:0] ST_DIV  = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_UPD;
        end
      end
      ST_UPD: begin
        cmd.update = 1'b1;
        state_nxt  = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul_load = 1'b1;
        state_nxt    = ST_DIV;
      end
      ST_DIV: begin
        if (status.div_done && out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

>>> src/wsaa_dp.sv
// window store, running totals, limit products, divider and result register
module wsaa_dp #(
  parameter int WINDOW_SIZE = 64
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  wsaa_pkg::ctrl_cmd_t                   cmd,
  output wsaa_pkg::dp_status_t                  status,
  input  logic [wsaa_pkg::CO2_W-1:0]            in_co2,
  input  logic [wsaa_pkg::HUM_W-1:0]            in_hum,
  input  logic signed [wsaa_pkg::TMP_W-1:0]     in_tmp,
  input  logic                                  in_vld,
  input  logic                                  in_restart,
  input  logic                                  cfg_we,
  input  logic [wsaa_pkg::CFG_ADDR_W-1:0]       cfg_addr,
  input  logic [wsaa_pkg::CFG_DATA_W-1:0]       cfg_wdata,
  output logic [wsaa_pkg::CO2_W-1:0]            avg_co2,
  output logic [wsaa_pkg::HUM_W-1:0]            avg_hum,
  output logic signed [wsaa_pkg::TMP_W-1:0]     avg_tmp,
  output logic                                  avg_valid,
  output logic                                  win_full,
  output logic [$clog2(WINDOW_SIZE+1)-1:0]      smp_count,
  output logic                                  co2_alert,
  output logic                                  tmp_alert,
  output logic                                  hum_alert,
  output logic                                  any_alert,
  output logic [wsaa_pkg::GRADE_W-1:0]          co2_grade
);

  localparam int CO2_W  = wsaa_pkg::CO2_W;
  localparam int HUM_W  = wsaa_pkg::HUM_W;
  localparam int TMP_W  = wsaa_pkg::TMP_W;
  localparam int LOG_W  = $clog2(WINDOW_SIZE);
  localparam int CNT_W  = $clog2(WINDOW_SIZE + 1);
  localparam int SLOT_W = (WINDOW_SIZE > 1) ? LOG_W : 1;
  localparam int CT_W   = CO2_W + LOG_W;
  localparam int HT_W   = HUM_W + LOG_W;
  localparam int TT_W   = TMP_W + LOG_W;
  localparam int DIV_W  = CT_W;
  localparam int MEM_W  = CO2_W + HUM_W + TMP_W;
  localparam int LPW    = CO2_W + CNT_W;
  localparam int CPW    = CO2_W + CNT_W + 2;
  localparam int HPW    = HUM_W + CNT_W;
  localparam int TPW    = TMP_W + CNT_W + 1;

  // configuration
  logic [CO2_W-1:0]        co2_lim_r;
  logic signed [TMP_W-1:0] tmp_lim_r;
  logic [HUM_W-1:0]        hum_lim_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      co2_lim_r <= wsaa_pkg::CO2_LIMIT_RST;
      tmp_lim_r <= wsaa_pkg::TMP_LIMIT_RST;
      hum_lim_r <= wsaa_pkg::HUM_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        wsaa_pkg::REG_CO2_LIMIT: co2_lim_r <= cfg_wdata[CO2_W-1:0];
        wsaa_pkg::REG_TMP_LIMIT: tmp_lim_r <= $signed(cfg_wdata[TMP_W-1:0]);
        wsaa_pkg::REG_HUM_LIMIT: hum_lim_r <= cfg_wdata[HUM_W-1:0];
        default: ;
      endcase
    end
  end

  // captured request
  logic [CO2_W-1:0]        smp_co2_r;
  logic [HUM_W-1:0]        smp_hum_r;
  logic signed [TMP_W-1:0] smp_tmp_r;
  logic                    smp_vld_r;
  logic                    smp_rst_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      smp_co2_r <= in_co2;
      smp_hum_r <= in_hum;
      smp_tmp_r <= in_tmp;
      smp_vld_r <= in_vld;
      smp_rst_r <= in_restart;
    end
  end

  // window state
  logic [SLOT_W-1:0]     slot_r, slot_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [CT_W-1:0]       co2_tot_r, co2_tot_nxt;
  logic [HT_W-1:0]       hum_tot_r, hum_tot_nxt;
  logic signed [TT_W-1:0] tmp_tot_r, tmp_tot_nxt;
  logic                  full;

  // window memory, oldest entry read when the request is taken
  logic [MEM_W-1:0] mem [WINDOW_SIZE];
  logic [MEM_W-1:0] rd_r;
  logic             wr_en;
  logic [MEM_W-1:0] wr_data;

  logic [CO2_W-1:0]        old_co2;
  logic [HUM_W-1:0]        old_hum;
  logic signed [TMP_W-1:0] old_tmp;

  assign wr_en   = cmd.update && !smp_rst_r && smp_vld_r;
  assign wr_data = {smp_co2_r, smp_hum_r, smp_tmp_r};
  assign old_co2 = rd_r[MEM_W-1 -: CO2_W];
  assign old_hum = rd_r[TMP_W +: HUM_W];
  assign old_tmp = $signed(rd_r[TMP_W-1:0]);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      rd_r <= mem[slot_r];
    end
    if (wr_en) begin
      mem[slot_r] <= wr_data;
    end
  end

  assign full = (cnt_r == CNT_W'(WINDOW_SIZE));

  always_comb begin
    slot_nxt    = slot_r;
    cnt_nxt     = cnt_r;
    co2_tot_nxt = co2_tot_r;
    hum_tot_nxt = hum_tot_r;
    tmp_tot_nxt = tmp_tot_r;
    if (cmd.update) begin
      if (smp_rst_r) begin
        slot_nxt    = '0;
        cnt_nxt     = '0;
        co2_tot_nxt = '0;
        hum_tot_nxt = '0;
        tmp_tot_nxt = '0;
      end else if (smp_vld_r) begin
        co2_tot_nxt = co2_tot_r + CT_W'(smp_co2_r) - (full ? CT_W'(old_co2) : CT_W'(0));
        hum_tot_nxt = hum_tot_r + HT_W'(smp_hum_r) - (full ? HT_W'(old_hum) : HT_W'(0));
        tmp_tot_nxt = tmp_tot_r + TT_W'(smp_tmp_r) - (full ? TT_W'(old_tmp) : TT_W'(0));
        cnt_nxt     = full ? cnt_r : cnt_r + CNT_W'(1);
        slot_nxt    = (slot_r == SLOT_W'(WINDOW_SIZE - 1)) ? '0 : slot_r + SLOT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r    <= '0;
      cnt_r     <= '0;
      co2_tot_r <= '0;
      hum_tot_r <= '0;
      tmp_tot_r <= '0;
    end else begin
      slot_r    <= slot_nxt;
      cnt_r     <= cnt_nxt;
      co2_tot_r <= co2_tot_nxt;
      hum_tot_r <= hum_tot_nxt;
      tmp_tot_r <= tmp_tot_nxt;
    end
  end

  // limit times fill count, so the alerts compare exact means
  logic [LPW-1:0]         lc_n_r;
  logic [HPW-1:0]         hl_n_r;
  logic signed [TPW-1:0]  tl_n_r;
  logic                   tneg_r;

  always_ff @(posedge clk) begin
    if (cmd.mul_load) begin
      lc_n_r <= LPW'(co2_lim_r) * LPW'(cnt_r);
      hl_n_r <= HPW'(hum_lim_r) * HPW'(cnt_r);
      tl_n_r <= TPW'(tmp_lim_r) * TPW'($signed({1'b0, cnt_r}));
      tneg_r <= tmp_tot_r[TT_W-1];
    end
  end

  // alert compares, stable while the divider runs
  logic [CPW-1:0]         co2_s, two_s, lcn, three_l, two_l;
  logic                   ca, ta, ha;
  logic [wsaa_pkg::GRADE_W-1:0] grade;
  logic                   ca_r, ta_r, ha_r;
  logic [wsaa_pkg::GRADE_W-1:0] grade_r;

  always_comb begin
    co2_s   = CPW'(co2_tot_r);
    two_s   = co2_s << 1;
    lcn     = CPW'(lc_n_r);
    three_l = lcn + (lcn << 1);
    two_l   = lcn << 1;
    ca      = (co2_s > lcn);
    ta      = (TPW'(tmp_tot_r) > tl_n_r);
    ha      = (HPW'(hum_tot_r) > hl_n_r);
    if (!ca) begin
      grade = wsaa_pkg::GRADE_NONE;
    end else if (two_s <= three_l) begin
      grade = wsaa_pkg::GRADE_LOW;
    end else if (co2_s <= two_l) begin
      grade = wsaa_pkg::GRADE_MID;
    end else begin
      grade = wsaa_pkg::GRADE_HIGH;
    end
  end

  always_ff @(posedge clk) begin
    ca_r    <= ca;
    ta_r    <= ta;
    ha_r    <= ha;
    grade_r <= grade;
  end

  // divider operands, temperature by magnitude
  logic signed [DIV_W:0] tmp_ext;
  logic signed [DIV_W:0] tmp_abs;
  logic [DIV_W-1:0]      dvd  [3];
  logic [DIV_W-1:0]      quot [3];
  logic                  div_done;

  always_comb begin
    tmp_ext = (DIV_W + 1)'(tmp_tot_r);
    tmp_abs = tmp_ext[DIV_W] ? -tmp_ext : tmp_ext;
    dvd[0]  = DIV_W'(co2_tot_r);
    dvd[1]  = DIV_W'(hum_tot_r);
    dvd[2]  = tmp_abs[DIV_W-1:0];
  end

  wsaa_div #(
    .DIV_W (DIV_W),
    .CNT_W (CNT_W),
    .LANES (3)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.mul_load),
    .divisor  (cnt_r),
    .dividend (dvd),
    .quot     (quot),
    .done     (div_done)
  );

  assign status.div_done = div_done;

  // result register
  logic [DIV_W-1:0]        tq;
  logic [CO2_W-1:0]        avg_co2_r;
  logic [HUM_W-1:0]        avg_hum_r;
  logic signed [TMP_W-1:0] avg_tmp_r;
  logic                    avg_valid_r, win_full_r;
  logic [CNT_W-1:0]        count_r;
  logic                    co2_alert_r, tmp_alert_r, hum_alert_r, any_alert_r;
  logic [wsaa_pkg::GRADE_W-1:0] co2_grade_r;

  assign tq = tneg_r ? -quot[2] : quot[2];

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      if (cnt_r == '0) begin
        avg_co2_r   <= '0;
        avg_hum_r   <= '0;
        avg_tmp_r   <= '0;
        avg_valid_r <= 1'b0;
        win_full_r  <= 1'b0;
        count_r     <= '0;
        co2_alert_r <= 1'b0;
        tmp_alert_r <= 1'b0;
        hum_alert_r <= 1'b0;
        any_alert_r <= 1'b0;
        co2_grade_r <= wsaa_pkg::GRADE_NONE;
      end else begin
        avg_co2_r   <= quot[0][CO2_W-1:0];
        avg_hum_r   <= quot[1][HUM_W-1:0];
        avg_tmp_r   <= $signed(tq[TMP_W-1:0]);
        avg_valid_r <= 1'b1;
        win_full_r  <= full;
        count_r     <= cnt_r;
        co2_alert_r <= ca_r;
        tmp_alert_r <= ta_r;
        hum_alert_r <= ha_r;
        any_alert_r <= ca_r || ta_r || ha_r;
        co2_grade_r <= grade_r;
      end
    end
  end

  assign avg_co2   = avg_co2_r;
  assign avg_hum   = avg_hum_r;
  assign avg_tmp   = avg_tmp_r;
  assign avg_valid = avg_valid_r;
  assign win_full  = win_full_r;
  assign smp_count = count_r;
  assign co2_alert = co2_alert_r;
  assign tmp_alert = tmp_alert_r;
  assign hum_alert = hum_alert_r;
  assign any_alert = any_alert_r;
  assign co2_grade = co2_grade_r;

endmodule

>>> src/windowed_sensor_average_alert.sv
// top level of the windowed sensor average alert block
// moving average over the last WINDOW_SIZE valid sensor requests (co2, humidity,
// temperature) with threshold alerts and a four-level co2 grade against 1, 1.5 and 2
// times the co2 limit. each request returns exactly one result. a request runs through
// these steps before the next one can be taken: taking the request plus the window
// memory read, the running total update and memory write, the limit products, the
// radix-2 restoring divider, whose three lanes share one step counter and run one
// quotient bit per cycle, and the load of the result register. the finished result
// sits in an output register, so a new request is taken while the previous result
// still waits; a result stalled at the output holds back the next one only at its
// final load. the limits may be written at any time the block is idle; reset sets
// co2 1000 ppm, temperature 30.00 C, humidity 70.00 %. the window memory needs no
// clearing after reset
module windowed_sensor_average_alert #(
  parameter int WINDOW_SIZE = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  wsaa_in_if.sink                             in_ch,
  wsaa_out_if.source                          out_ch,
  input  logic                                cfg_we,
  input  logic [wsaa_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [wsaa_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int CNT_W = $clog2(WINDOW_SIZE + 1);

  wsaa_pkg::ctrl_cmd_t  cmd;
  wsaa_pkg::dp_status_t status;
  logic                 in_ready;
  logic                 out_valid;
  logic [CNT_W-1:0]     smp_count;

  // sequencer: idle, window update, products and divider start, divide and load
  wsaa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // window store, totals, compares, divider and result register
  wsaa_dp #(
    .WINDOW_SIZE (WINDOW_SIZE)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .status     (status),
    .in_co2     (in_ch.co2_sample),
    .in_hum     (in_ch.humidity_sample),
    .in_tmp     (in_ch.temperature_sample),
    .in_vld     (in_ch.sample_valid),
    .in_restart (in_ch.restart),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .avg_co2    (out_ch.avg_co2),
    .avg_hum    (out_ch.avg_humidity),
    .avg_tmp    (out_ch.avg_temperature),
    .avg_valid  (out_ch.average_valid),
    .win_full   (out_ch.window_full),
    .smp_count  (smp_count),
    .co2_alert  (out_ch.co2_alert),
    .tmp_alert  (out_ch.temperature_alert),
    .hum_alert  (out_ch.humidity_alert),
    .any_alert  (out_ch.any_alert),
    .co2_grade  (out_ch.co2_grade)
  );

  // handshake outputs
  assign in_ch.ready         = in_ready;
  assign out_ch.valid        = out_valid;
  assign out_ch.sample_count = smp_count;

endmodule

>>> src/wsaa_checker.sv
// port-level assertions for the windowed sensor average alert block, with its bind
module wsaa_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [wsaa_pkg::CO2_W-1:0]    avg_co2,
  input logic [wsaa_pkg::HUM_W-1:0]    avg_humidity,
  input logic [wsaa_pkg::TMP_W-1:0]    avg_temperature,
  input logic                          average_valid,
  input logic                          window_full,
  input logic                          co2_alert,
  input logic                          temperature_alert,
  input logic                          humidity_alert,
  input logic                          any_alert,
  input logic [wsaa_pkg::GRADE_W-1:0]  co2_grade
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(avg_co2) && $stable(co2_grade)
      && $stable(any_alert))
    else $error("stalled result changed");

  // one request at a time: no new request right after one is taken
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while previous one in progress");

  // empty window gives an all-zero result
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !average_valid |-> avg_co2 == '0 && avg_humidity == '0
      && avg_temperature == '0 && !window_full && !any_alert
      && co2_grade == wsaa_pkg::GRADE_NONE)
    else $error("empty window result not zero");

  // any alert is the or of the three alerts
  a_any_alert: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> any_alert == (co2_alert || temperature_alert || humidity_alert))
    else $error("any alert inconsistent");

  // co2 grade is none exactly when there is no co2 alert
  a_grade_alert: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (co2_grade == wsaa_pkg::GRADE_NONE) == !co2_alert)
    else $error("co2 grade inconsistent with co2 alert");

endmodule

bind windowed_sensor_average_alert wsaa_checker u_wsaa_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_ch.valid),
  .in_ready          (in_ch.ready),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .avg_co2           (out_ch.avg_co2),
  .avg_humidity      (out_ch.avg_humidity),
  .avg_temperature   (out_ch.avg_temperature),
  .average_valid     (out_ch.average_valid),
  .window_full       (out_ch.window_full),
  .co2_alert         (out_ch.co2_alert),
  .temperature_alert (out_ch.temperature_alert),
  .humidity_alert    (out_ch.humidity_alert),
  .any_alert         (out_ch.any_alert),
  .co2_grade         (out_ch.co2_grade)
);

>>> tb/windowed_sensor_average_alert_test.sv
// self-checking testbench of the windowed sensor average alert block
`timescale 1ns / 1ps

module windowed_sensor_average_alert_test;

  localparam int CO2_W = wsaa_pkg::CO2_W;
  localparam int HUM_W = wsaa_pkg::HUM_W;
  localparam int TMP_W = wsaa_pkg::TMP_W;
  localparam int GRADE_W = wsaa_pkg::GRADE_W;
  localparam int CFG_ADDR_W = wsaa_pkg::CFG_ADDR_W;
  localparam int CFG_DATA_W = wsaa_pkg::CFG_DATA_W;
  localparam int WINDOW = 64;
  localparam int CNT_W = $clog2(WINDOW + 1);
  localparam int ITEMS_PER_PHASE = 343;
  localparam int LONG_HOLD = 250;
  localparam int DRAIN_CYCLES = 30;
  // index past the register list, writes to it must be dropped
  localparam logic [CFG_ADDR_W-1:0] REG_UNUSED = 2'd3;

  // one request as seen on the input channel
  typedef struct packed {
    logic [CO2_W-1:0]        co2;
    logic [HUM_W-1:0]        hum;
    logic signed [TMP_W-1:0] tmp;
    logic                    sample_valid;
    logic                    restart;
  } sensor_request_t;

  // one result as seen on the output channel
  typedef struct packed {
    logic [CO2_W-1:0]        avg_co2;
    logic [HUM_W-1:0]        avg_hum;
    logic signed [TMP_W-1:0] avg_tmp;
    logic                    average_valid;
    logic                    window_full;
    logic [CNT_W-1:0]        sample_count;
    logic                    co2_alert;
    logic                    tmp_alert;
    logic                    hum_alert;
    logic                    any_alert;
    logic [GRADE_W-1:0]      co2_grade;
  } window_result_t;

  // keeps its own ring window and running sums, predicts the averages and alerts
  class avg_alert_scoreboard;
    int co2_win [WINDOW];
    int hum_win [WINDOW];
    int tmp_win [WINDOW];
    int slot;
    int fill;
    longint co2_sum;
    longint hum_sum;
    longint tmp_sum;
    int co2_lim;
    int tmp_lim;
    int hum_lim;
    window_result_t expected_q [$];
    int mismatches;
    int requests;
    int restarts;
    int invalids;
    int results;
    int full_seen;
    int alert_seen;
    int grade_seen [4];

    function new();
      slot = 0;
      fill = 0;
      co2_sum = 0;
      hum_sum = 0;
      tmp_sum = 0;
      co2_lim = int'(wsaa_pkg::CO2_LIMIT_RST);
      tmp_lim = int'(wsaa_pkg::TMP_LIMIT_RST);
      hum_lim = int'(wsaa_pkg::HUM_LIMIT_RST);
      mismatches = 0;
      requests = 0;
      restarts = 0;
      invalids = 0;
      results = 0;
      full_seen = 0;
      alert_seen = 0;
      foreach (grade_seen[g]) grade_seen[g] = 0;
    endfunction

    function void write_limit(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
      case (addr)
        wsaa_pkg::REG_CO2_LIMIT: co2_lim = int'(data[CO2_W-1:0]);
        wsaa_pkg::REG_TMP_LIMIT: tmp_lim = int'($signed(data[TMP_W-1:0]));
        wsaa_pkg::REG_HUM_LIMIT: hum_lim = int'(data[HUM_W-1:0]);
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void note_request(sensor_request_t r);
      window_result_t e;
      longint n;
      logic ca, ta, ha;
      requests++;
      if (r.restart) begin
        restarts++;
        slot = 0;
        fill = 0;
        co2_sum = 0;
        hum_sum = 0;
        tmp_sum = 0;
      end else if (r.sample_valid) begin
        // full window: oldest entry leaves the sums before it is overwritten
        if (fill >= WINDOW) begin
          co2_sum -= co2_win[slot];
          hum_sum -= hum_win[slot];
          tmp_sum -= tmp_win[slot];
        end else begin
          fill++;
        end
        co2_win[slot] = int'(r.co2);
        hum_win[slot] = int'(r.hum);
        tmp_win[slot] = int'($signed(r.tmp));
        co2_sum += co2_win[slot];
        hum_sum += hum_win[slot];
        tmp_sum += tmp_win[slot];
        slot = (slot + 1) % WINDOW;
      end else begin
        invalids++;
      end

      e = '0;
      if (fill != 0) begin
        n = fill;
        // alerts and grade use the exact mean, compared as sum against limit times count
        ca = co2_sum > co2_lim * n;
        ta = tmp_sum > tmp_lim * n;
        ha = hum_sum > hum_lim * n;
        if (!ca) e.co2_grade = wsaa_pkg::GRADE_NONE;
        else if (2 * co2_sum <= 3 * co2_lim * n) e.co2_grade = wsaa_pkg::GRADE_LOW;
        else if (co2_sum <= 2 * co2_lim * n) e.co2_grade = wsaa_pkg::GRADE_MID;
        else e.co2_grade = wsaa_pkg::GRADE_HIGH;
        e.avg_co2 = CO2_W'(co2_sum / n);
        e.avg_hum = HUM_W'(hum_sum / n);
        e.avg_tmp = TMP_W'(tmp_sum / n);
        e.average_valid = 1'b1;
        e.window_full = (fill == WINDOW);
        e.sample_count = CNT_W'(fill);
        e.co2_alert = ca;
        e.tmp_alert = ta;
        e.hum_alert = ha;
        e.any_alert = ca | ta | ha;
      end
      expected_q.push_back(e);
    endfunction

    function void compare_field(string name, longint want, longint seen);
      if (want != seen) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch in result %0d, %s: expected %0d, got %0d",
                   results, name, want, seen);
      end
    endfunction

    function void check_result(window_result_t got);
      window_result_t e;
      results++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d arrived with no request waiting: %p", results, got);
        return;
      end
      e = expected_q.pop_front();
      compare_field("avg_co2", e.avg_co2, got.avg_co2);
      compare_field("avg_humidity", e.avg_hum, got.avg_hum);
      compare_field("avg_temperature", $signed(e.avg_tmp), $signed(got.avg_tmp));
      compare_field("average_valid", e.average_valid, got.average_valid);
      compare_field("window_full", e.window_full, got.window_full);
      compare_field("sample_count", e.sample_count, got.sample_count);
      compare_field("co2_alert", e.co2_alert, got.co2_alert);
      compare_field("temperature_alert", e.tmp_alert, got.tmp_alert);
      compare_field("humidity_alert", e.hum_alert, got.hum_alert);
      compare_field("any_alert", e.any_alert, got.any_alert);
      compare_field("co2_grade", e.co2_grade, got.co2_grade);
      if (e.window_full) full_seen++;
      if (e.any_alert) alert_seen++;
      grade_seen[e.co2_grade]++;
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  wsaa_in_if in_ch ();
  wsaa_out_if #(.WINDOW_SIZE(WINDOW)) out_ch ();

  avg_alert_scoreboard sb;

  // idle percentages of the two sides, changed per phase
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  // the result side serves one long hold-off per ask
  int hold_asks = 0;
  int hold_served = 0;

  windowed_sensor_average_alert #(
    .WINDOW_SIZE(WINDOW)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // handshakes are sampled at the rising edge, before the block updates
  always @(posedge clk) begin
    window_result_t got;
    sensor_request_t req;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        got.avg_co2 = out_ch.avg_co2;
        got.avg_hum = out_ch.avg_humidity;
        got.avg_tmp = out_ch.avg_temperature;
        got.average_valid = out_ch.average_valid;
        got.window_full = out_ch.window_full;
        got.sample_count = out_ch.sample_count;
        got.co2_alert = out_ch.co2_alert;
        got.tmp_alert = out_ch.temperature_alert;
        got.hum_alert = out_ch.humidity_alert;
        got.any_alert = out_ch.any_alert;
        got.co2_grade = out_ch.co2_grade;
        sb.check_result(got);
      end
      if (in_ch.valid && in_ch.ready) begin
        req.co2 = in_ch.co2_sample;
        req.hum = in_ch.humidity_sample;
        req.tmp = in_ch.temperature_sample;
        req.sample_valid = in_ch.sample_valid;
        req.restart = in_ch.restart;
        sb.note_request(req);
      end
    end
  end

  // result side: random stalls, plus a long hold-off counted here when asked
  initial begin : result_sink
    int hold_left;
    hold_left = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_asks != hold_served) begin
        hold_served = hold_asks;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // offers one request, with a random gap first; entered and left at a falling edge
  task automatic send_request(input int c, input int h, input int t, input bit v, input bit r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.co2_sample <= c[CO2_W-1:0];
    in_ch.humidity_sample <= h[HUM_W-1:0];
    in_ch.temperature_sample <= t[TMP_W-1:0];
    in_ch.sample_valid <= v;
    in_ch.restart <= r;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  // drops valid and waits until every result is back
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (sb.pending() != 0);
  endtask

  // writes all three limits and the unused index, block idle
  task automatic program_limits(input int co2_l, input int tmp_l, input int hum_l);
    logic [CFG_DATA_W-1:0] data [4];
    logic [CFG_ADDR_W-1:0] addr [4];
    addr[0] = wsaa_pkg::REG_CO2_LIMIT;
    data[0] = co2_l[CFG_DATA_W-1:0];
    addr[1] = wsaa_pkg::REG_TMP_LIMIT;
    data[1] = tmp_l[CFG_DATA_W-1:0];
    addr[2] = wsaa_pkg::REG_HUM_LIMIT;
    data[2] = hum_l[CFG_DATA_W-1:0];
    // junk to the unused index must not disturb any limit
    addr[3] = REG_UNUSED;
    data[3] = CFG_DATA_W'($urandom);
    for (int i = 0; i < 4; i++) begin
      cfg_we <= 1'b1;
      cfg_addr <= addr[i];
      cfg_wdata <= data[i];
      sb.write_limit(addr[i], data[i]);
      @(negedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  function automatic int clamp(int x, int lo, int hi);
    return (x < lo) ? lo : ((x > hi) ? hi : x);
  endfunction

  function automatic int jitter(int spread);
    return int'($urandom_range(2 * spread)) - spread;
  endfunction

  // mostly runs of valid samples drifting around moving levels, so the means
  // sweep across the limits; rare restarts and invalid samples, a few raw bit patterns
  task automatic random_requests(input int count);
    int co2_lvl, hum_lvl, tmp_lvl, co2_span, roll;
    int c, h, t;
    bit v, r;
    co2_lvl = 0;
    hum_lvl = 0;
    tmp_lvl = 0;
    co2_span = 1;
    for (int i = 0; i < count; i++) begin
      if (i % 48 == 0 || $urandom_range(29) == 0) begin
        co2_span = clamp(sb.co2_lim * 5 / 2 + 200, 1, 65535);
        co2_lvl = int'($urandom_range(co2_span));
        hum_lvl = int'($urandom_range(10000));
        tmp_lvl = int'($urandom_range(16500)) - 4000;
      end
      c = clamp(co2_lvl + jitter(co2_span / 10 + 1), 0, 65535);
      h = clamp(hum_lvl + jitter(600), 0, 10000);
      t = clamp(tmp_lvl + jitter(900), -4000, 12500);
      // raw patterns outside the stated ranges
      if ($urandom_range(99) < 5) begin
        c = int'($urandom);
        h = int'($urandom);
        t = int'($urandom);
      end
      roll = int'($urandom_range(99));
      r = (roll == 0);
      v = r ? bit'($urandom_range(1)) : (roll >= 9);
      send_request(c, h, t, v, r);
    end
  endtask

  initial begin : stimulus
    int errors;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_addr = '0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.co2_sample = '0;
    in_ch.humidity_sample = '0;
    in_ch.temperature_sample = '0;
    in_ch.sample_valid = 1'b0;
    in_ch.restart = 1'b0;
    sb = new();
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed part at the reset limits (1000 ppm, 30.00 C, 70.00 %)
    // empty window: invalid and restart both give an all-zero result
    send_request(65535, 16383, -16384, 1'b0, 1'b0);
    send_request(65535, 16383, 16383, 1'b1, 1'b1);
    // field extremes, including raw patterns beyond the stated ranges
    send_request(0, 0, 0, 1'b1, 1'b0);
    send_request(65535, 16383, 16383, 1'b1, 1'b0);
    send_request(65535, 16383, -16384, 1'b1, 1'b0);
    send_request(1000, 10000, -4000, 1'b1, 1'b0);
    // invalid sample on a filled window leaves it alone
    send_request(12345, 321, 7777, 1'b0, 1'b0);
    send_request(1500, 0, 12500, 1'b1, 1'b0);
    // means exactly at the limits raise nothing, just above does
    send_request(0, 0, 0, 1'b0, 1'b1);
    send_request(1000, 7000, 3000, 1'b1, 1'b0);
    send_request(1001, 7001, 3001, 1'b1, 1'b0);
    // grade steps at 1.5 and 2 times the co2 limit
    send_request(0, 0, 0, 1'b0, 1'b1);
    send_request(1500, 0, 0, 1'b1, 1'b0);
    send_request(0, 0, 0, 1'b0, 1'b1);
    send_request(1501, 0, 0, 1'b1, 1'b0);
    send_request(0, 0, 0, 1'b0, 1'b1);
    send_request(2000, 0, 0, 1'b1, 1'b0);
    send_request(0, 0, 0, 1'b0, 1'b1);
    send_request(2001, 0, 0, 1'b1, 1'b0);
    // negative mean truncates toward zero
    send_request(0, 0, 0, 1'b0, 1'b1);
    send_request(1, 1, -3, 1'b1, 1'b0);
    send_request(2, 2, -4, 1'b1, 1'b0);
    wait_idle();

    // lowest limits, sender mostly busy, receiver often stalling
    program_limits(0, -4000, 0);
    send_idle_pct = 11;
    recv_idle_pct = 66;
    random_requests(ITEMS_PER_PHASE);
    wait_idle();

    // highest limits, roles of the two sides swapped
    program_limits(65535, 12500, 10000);
    send_idle_pct = 66;
    recv_idle_pct = 11;
    random_requests(ITEMS_PER_PHASE);
    wait_idle();

    // mid limits, no idling; one long hold-off backs the block up to its input
    program_limits(1200, 2500, 5500);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_asks++;
    random_requests(ITEMS_PER_PHASE);
    wait_idle();

    // late or extra results would show up here
    repeat (DRAIN_CYCLES) @(negedge clk);
    errors = sb.mismatches + sb.pending();
    $display("covered %0d requests (%0d restarts, %0d invalid samples) under four limit sets",
             sb.requests, sb.restarts, sb.invalids);
    $display("checked %0d results: %0d on a full window, %0d alerting, grades %0d/%0d/%0d/%0d",
             sb.results, sb.full_seen, sb.alert_seen, sb.grade_seen[0], sb.grade_seen[1],
             sb.grade_seen[2], sb.grade_seen[3]);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin : watchdog
    #5000000;
    $display("timeout with %0d results still pending", sb.pending());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
